// ----- rtl/tcs_pkg.sv -----
// Shared types and constants for the text console with scrollback.
// Used by tcs_cell_unit and text_console_with_scrollback_core; no dependencies.
package tcs_pkg;

  // Operations of the shared cell unit
  typedef enum logic [1:0] {
    UOP_FILL,
    UOP_SCAN,
    UOP_WRITE,
    UOP_READ
  } unit_op_e;

  // Command from the sequencer to the cell unit
  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_cmd_t;

  // Status from the cell unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Input function codes
  localparam logic [2:0] FUNC_PUT   = 3'd0;
  localparam logic [2:0] FUNC_LEFT  = 3'd1;
  localparam logic [2:0] FUNC_RIGHT = 3'd2;
  localparam logic [2:0] FUNC_UP    = 3'd3;
  localparam logic [2:0] FUNC_DOWN  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  // Character codes with special handling
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_BACK    = 8'd8;

  // Cell layout: character in the low byte, color in the high byte
  localparam logic [15:0] CHAR_MASK  = 16'h00FF;
  localparam logic [15:0] CLEAR_CELL = 16'h0F00;
  localparam logic [7:0]  COLOR_RST  = 8'd15;

endpackage

// ----- rtl/tcs_cell_ram.sv -----
// Scrollback cell store: one write port, one read port, registered read data.
// No package dependency; instantiated by tcs_cell_unit.
module tcs_cell_ram #(
  parameter int AW    = 14,
  parameter int DEPTH = 16384
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tcs_cell_unit.sv -----
// Shared cell unit: row fill, row-length scan, single write and single read.
// Holds the cell store (tcs_cell_ram); uses tcs_pkg for command and status types.
module tcs_cell_unit #(
  parameter int SCREEN_COLS  = 80,
  parameter int HISTORY_ROWS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcs_pkg::unit_cmd_t                cmd_i,
  input  logic [$clog2(HISTORY_ROWS)-1:0]   row_i,
  input  logic [$clog2(SCREEN_COLS)-1:0]    col_i,
  input  logic [15:0]                       data_i,
  output tcs_pkg::unit_sts_t                sts_o,
  output logic [$clog2(SCREEN_COLS+1)-1:0]  len_o,
  output logic [15:0]                       rdata_o
);

  localparam int RW    = $clog2(HISTORY_ROWS);
  localparam int CAW   = $clog2(SCREEN_COLS);
  localparam int CW    = $clog2(SCREEN_COLS + 1);
  localparam int AW    = RW + CAW;
  localparam int DEPTH = HISTORY_ROWS * (1 << CAW);
  localparam logic [CAW-1:0] COL_LAST = CAW'(SCREEN_COLS - 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_RDWAIT
  } ustate_e;

  ustate_e           state_q;
  tcs_pkg::unit_op_e op_q;
  logic [RW-1:0]     row_q;
  logic [CAW-1:0]    col_q;
  logic [CAW-1:0]    pcol_q;
  logic              pend_q;
  logic [15:0]       data_q;
  logic              done_q;
  logic [CW-1:0]     len_q;
  logic [15:0]       rdata_q;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  logic [15:0]       ram_rdata;
  logic              char_hit;

  // memory control follows the latched operation
  always_comb begin
    ram_addr = {row_q, col_q};
    ram_we   = (state_q == U_RUN) &&
               (op_q == tcs_pkg::UOP_FILL || op_q == tcs_pkg::UOP_WRITE);
    ram_re   = (state_q == U_RUN) &&
               (op_q == tcs_pkg::UOP_SCAN || op_q == tcs_pkg::UOP_READ);
    char_hit = (ram_rdata & tcs_pkg::CHAR_MASK) != 16'h0000;
  end

  tcs_cell_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (data_q),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // sequencer: one cell per cycle; the scan walks from the last column down
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      op_q    <= tcs_pkg::UOP_FILL;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      pcol_q  <= '0;
      data_q  <= '0;
      len_q   <= '0;
      rdata_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          pend_q <= 1'b0;
          if (cmd_i.start) begin
            op_q    <= cmd_i.op;
            row_q   <= row_i;
            data_q  <= data_i;
            state_q <= U_RUN;
            unique case (cmd_i.op)
              tcs_pkg::UOP_FILL: col_q <= '0;
              tcs_pkg::UOP_SCAN: col_q <= COL_LAST;
              default:           col_q <= col_i;
            endcase
          end
        end
        U_RUN: begin
          unique case (op_q)
            tcs_pkg::UOP_FILL: begin
              if (col_q == COL_LAST) begin
                done_q  <= 1'b1;
                state_q <= U_IDLE;
              end else begin
                col_q <= col_q + CAW'(1);
              end
            end
            tcs_pkg::UOP_WRITE: begin
              done_q  <= 1'b1;
              state_q <= U_IDLE;
            end
            tcs_pkg::UOP_READ: begin
              state_q <= U_RDWAIT;
            end
            tcs_pkg::UOP_SCAN: begin
              // read data belongs to the column issued in the previous cycle, held in pcol_q
              if (pend_q && char_hit) begin
                len_q   <= CW'(pcol_q) + CW'(1);
                done_q  <= 1'b1;
                pend_q  <= 1'b0;
                state_q <= U_IDLE;
              end else if (pend_q && pcol_q == '0) begin
                len_q   <= '0;
                done_q  <= 1'b1;
                pend_q  <= 1'b0;
                state_q <= U_IDLE;
              end else begin
                pend_q <= 1'b1;
                pcol_q <= col_q;
                if (col_q != '0) begin
                  col_q <= col_q - CAW'(1);
                end
              end
            end
            default: state_q <= U_IDLE;
          endcase
        end
        U_RDWAIT: begin
          rdata_q <= ram_rdata;
          done_q  <= 1'b1;
          state_q <= U_IDLE;
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_q != U_IDLE);
  assign sts_o.done = done_q;
  assign len_o      = len_q;
  assign rdata_o    = rdata_q;

  // a new command only arrives while the unit is free
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !sts_o.busy)
    else $error("cell unit started while busy");

  // completion is a single-cycle pulse that returns the unit to idle
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == U_IDLE) ##1 !done_q)
    else $error("cell unit done not a single pulse");

  // a row length never exceeds the row width
  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (len_q <= CW'(SCREEN_COLS)))
    else $error("scan length out of range");

  // writes never happen while a scan or read is running
  a_no_write_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> !ram_we)
    else $error("cell store written during a read operation");

endmodule

// ----- rtl/text_console_with_scrollback_core.sv -----
// Text console with scrollback: cursor, viewport and history sequencer.
// Depends on tcs_pkg and tcs_cell_unit (which holds the cell store).
//
//  channel   direction  handshake                    payload
//  command   in         start & !busy                func_i, char_code_i, read_row_i, read_col_i
//  result    out        done_o, one cycle, no stall  cursor_col_o, cursor_row_o,
//                                                    cursor_screen_row_o, view_top_o, cell_value_o
//  config    in         cfg_valid_i & cfg_ready_o    text_color_i
//
// One item at a time; busy stays high after the transfer until the item is done,
// and the result strobe comes in the first cycle with busy low. A put char does
// a single write and a read a single read in the cell unit, a newline a row step,
// and return, tab, backspace, spare codes or an out-of-range read go straight to
// the result. A wrap before or after the write adds a row step, and a scroll adds
// a row fill. Arrow items scan at most one row in the cell unit; a right arrow
// that looks at the next row scans two. The single cell-unit port to the store
// carries all of these steps in turn.
// After reset a clearing pass fills the store one row per fill, with busy high;
// config writes are taken.
// History scrolls by moving a ring base row, so a scroll only clears one row.
// The result is shown for one cycle under done_o and cannot be held off.
module text_console_with_scrollback_core #(
  parameter int SCREEN_COLS  = 80,
  parameter int SCREEN_ROWS  = 25,
  parameter int HISTORY_ROWS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        done_o,
  output logic [6:0]  cursor_col_o,
  output logic [6:0]  cursor_row_o,
  output logic [4:0]  cursor_screen_row_o,
  output logic [6:0]  view_top_o,
  output logic [15:0] cell_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  text_color_i
);

  localparam int RW  = $clog2(HISTORY_ROWS);
  localparam int RW1 = RW + 1;
  localparam int CAW = $clog2(SCREEN_COLS);
  localparam int CW  = $clog2(SCREEN_COLS + 1);

  localparam logic [RW:0]   H_W     = RW1'(HISTORY_ROWS);
  localparam logic [RW:0]   SR_W    = RW1'(SCREEN_ROWS);
  localparam logic [RW:0]   SR_M1   = RW1'(SCREEN_ROWS - 1);
  localparam logic [RW-1:0] H_LAST  = RW'(HISTORY_ROWS - 1);
  localparam logic [RW-1:0] TOP_MAX = RW'(HISTORY_ROWS - SCREEN_ROWS);
  localparam logic [CW-1:0] COLS_W  = CW'(SCREEN_COLS);

  typedef enum logic [2:0] {
    ST_CLEAR_GO,
    ST_CLEAR_WAIT,
    ST_IDLE,
    ST_ROWDN,
    ST_WAIT,
    ST_NEXT,
    ST_OUT
  } state_e;

  // what to do once the pending row step or unit operation completes
  typedef enum logic [3:0] {
    K_END,
    K_WRITE,
    K_ADV,
    K_LEFT,
    K_RIGHT,
    K_RIGHT2,
    K_MIN,
    K_SETCOL,
    K_SCANMIN,
    K_READ
  } step_e;

  state_e             state_q;
  step_e              step_q;
  logic [RW-1:0]      cur_row_q;
  logic [CW-1:0]      cur_col_q;
  logic [RW-1:0]      last_q;
  logic [RW-1:0]      top_q;
  logic [RW-1:0]      base_q;
  logic [RW-1:0]      clr_row_q;
  logic [7:0]         color_q;
  logic [7:0]         ch_q;
  logic [15:0]        cell_q;
  logic               done_q;

  tcs_pkg::unit_cmd_t cmd_q;
  logic [RW-1:0]      urow_q;
  logic [CAW-1:0]     ucol_q;
  logic [15:0]        udata_q;
  tcs_pkg::unit_sts_t usts;
  logic [CW-1:0]      lim;
  logic [15:0]        urdata;

  logic [RW:0]        nxt_row;
  logic               rd_scroll;
  logic [RW-1:0]      rd_row;
  logic [RW-1:0]      rd_last;
  logic [RW-1:0]      rd_top;
  logic [RW-1:0]      up_row;
  logic [RW-1:0]      up_top;
  logic [RW-1:0]      base_inc;
  logic [CW-1:0]      col_min;
  logic               read_ok;

  // logical history row to ring position
  function automatic logic [RW-1:0] phys(input logic [RW-1:0] r, input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= H_W) begin
      s = s - H_W;
    end
    return s[RW-1:0];
  endfunction

  // row-down and row-up results from the current cursor state
  always_comb begin
    nxt_row   = {1'b0, cur_row_q} + RW1'(1);
    rd_scroll = (nxt_row >= H_W);
    if (rd_scroll) begin
      rd_row  = H_LAST;
      rd_last = H_LAST;
      rd_top  = TOP_MAX;
    end else begin
      rd_row  = nxt_row[RW-1:0];
      rd_last = (nxt_row > {1'b0, last_q}) ? nxt_row[RW-1:0] : last_q;
      rd_top  = (nxt_row >= ({1'b0, top_q} + SR_W)) ? RW'(nxt_row - SR_M1) : top_q;
    end
    up_row   = cur_row_q - RW'(1);
    up_top   = (up_row < top_q) ? up_row : top_q;
    base_inc = (({1'b0, base_q} + RW1'(1)) == H_W) ? '0 : base_q + RW'(1);
    col_min  = (cur_col_q > lim) ? lim : cur_col_q;
    read_ok  = (int'(read_row_i) < HISTORY_ROWS) && (int'(read_col_i) < SCREEN_COLS);
  end

  tcs_cell_unit #(
    .SCREEN_COLS  (SCREEN_COLS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_q),
    .row_i   (urow_q),
    .col_i   (ucol_q),
    .data_i  (udata_q),
    .sts_o   (usts),
    .len_o   (lim),
    .rdata_o (urdata)
  );

  // color register transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tcs_pkg::COLOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= text_color_i;
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR_GO;
      step_q    <= K_END;
      cur_row_q <= '0;
      cur_col_q <= '0;
      last_q    <= '0;
      top_q     <= '0;
      base_q    <= '0;
      clr_row_q <= '0;
      done_q    <= 1'b0;
      cmd_q     <= '{start: 1'b0, op: tcs_pkg::UOP_FILL};
      urow_q    <= '0;
      ucol_q    <= '0;
      udata_q   <= '0;
      ch_q      <= '0;
      cell_q    <= '0;
    end else begin
      done_q      <= 1'b0;
      cmd_q.start <= 1'b0;
      unique case (state_q)
        // clearing pass after reset, one row per fill
        ST_CLEAR_GO: begin
          cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_FILL};
          urow_q  <= clr_row_q;
          udata_q <= tcs_pkg::CLEAR_CELL;
          state_q <= ST_CLEAR_WAIT;
        end
        ST_CLEAR_WAIT: begin
          if (usts.done) begin
            if (clr_row_q == H_LAST) begin
              state_q <= ST_IDLE;
            end else begin
              clr_row_q <= clr_row_q + RW'(1);
              state_q   <= ST_CLEAR_GO;
            end
          end
        end
        // item transfer and dispatch
        ST_IDLE: begin
          if (start) begin
            ch_q   <= char_code_i;
            cell_q <= '0;
            unique case (func_i)
              tcs_pkg::FUNC_PUT: begin
                if (char_code_i == tcs_pkg::CH_NEWLINE) begin
                  cur_col_q <= '0;
                  step_q    <= K_END;
                  state_q   <= ST_ROWDN;
                end else if (char_code_i == tcs_pkg::CH_RETURN ||
                             char_code_i == tcs_pkg::CH_TAB ||
                             char_code_i == tcs_pkg::CH_BACK) begin
                  state_q <= ST_OUT;
                end else if (cur_col_q >= COLS_W) begin
                  // wrap before writing
                  cur_col_q <= '0;
                  step_q    <= K_WRITE;
                  state_q   <= ST_ROWDN;
                end else begin
                  step_q  <= K_WRITE;
                  state_q <= ST_NEXT;
                end
              end
              tcs_pkg::FUNC_LEFT: begin
                if (cur_col_q == '0 && cur_row_q != '0) begin
                  cur_row_q <= up_row;
                  top_q     <= up_top;
                  cmd_q     <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
                  urow_q    <= phys(up_row, base_q);
                  step_q    <= K_SETCOL;
                  state_q   <= ST_WAIT;
                end else if (cur_col_q != '0) begin
                  cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
                  urow_q  <= phys(cur_row_q, base_q);
                  step_q  <= K_LEFT;
                  state_q <= ST_WAIT;
                end else begin
                  state_q <= ST_OUT;
                end
              end
              tcs_pkg::FUNC_RIGHT: begin
                cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
                urow_q  <= phys(cur_row_q, base_q);
                step_q  <= K_RIGHT;
                state_q <= ST_WAIT;
              end
              tcs_pkg::FUNC_UP: begin
                if (cur_row_q != '0) begin
                  cur_row_q <= up_row;
                  top_q     <= up_top;
                  cmd_q     <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
                  urow_q    <= phys(up_row, base_q);
                  step_q    <= K_MIN;
                  state_q   <= ST_WAIT;
                end else begin
                  state_q <= ST_OUT;
                end
              end
              tcs_pkg::FUNC_DOWN: begin
                if (cur_row_q < last_q) begin
                  step_q  <= K_SCANMIN;
                  state_q <= ST_ROWDN;
                end else begin
                  cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
                  urow_q  <= phys(cur_row_q, base_q);
                  step_q  <= K_SETCOL;
                  state_q <= ST_WAIT;
                end
              end
              tcs_pkg::FUNC_READ: begin
                if (read_ok) begin
                  cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_READ};
                  urow_q  <= phys(RW'(read_row_i), base_q);
                  ucol_q  <= CAW'(read_col_i);
                  step_q  <= K_READ;
                  state_q <= ST_WAIT;
                end else begin
                  state_q <= ST_OUT;
                end
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        // cursor one row down; scrolling moves the ring base and clears a row
        ST_ROWDN: begin
          cur_row_q <= rd_row;
          last_q    <= rd_last;
          top_q     <= rd_top;
          if (rd_scroll) begin
            base_q  <= base_inc;
            cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_FILL};
            urow_q  <= base_q;
            udata_q <= {color_q, 8'h00};
            state_q <= ST_WAIT;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_WAIT: begin
          if (usts.done) begin
            state_q <= ST_NEXT;
          end
        end
        // continuation after a row step or a unit operation
        ST_NEXT: begin
          state_q <= ST_OUT;
          unique case (step_q)
            K_END: ;
            K_WRITE: begin
              cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_WRITE};
              urow_q  <= phys(cur_row_q, base_q);
              ucol_q  <= CAW'(cur_col_q);
              udata_q <= {color_q, ch_q};
              step_q  <= K_ADV;
              state_q <= ST_WAIT;
            end
            K_ADV: begin
              if ((cur_col_q + CW'(1)) >= COLS_W) begin
                cur_col_q <= '0;
                step_q    <= K_END;
                state_q   <= ST_ROWDN;
              end else begin
                cur_col_q <= cur_col_q + CW'(1);
              end
            end
            K_LEFT: begin
              cur_col_q <= (cur_col_q > lim) ? lim : cur_col_q - CW'(1);
            end
            K_RIGHT: begin
              if (cur_col_q < lim) begin
                cur_col_q <= cur_col_q + CW'(1);
              end else if (cur_col_q == lim && nxt_row < H_W) begin
                cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
                urow_q  <= phys(nxt_row[RW-1:0], base_q);
                step_q  <= K_RIGHT2;
                state_q <= ST_WAIT;
              end
            end
            K_RIGHT2: begin
              if (lim != '0) begin
                cur_col_q <= '0;
                step_q    <= K_END;
                state_q   <= ST_ROWDN;
              end
            end
            K_MIN:    cur_col_q <= col_min;
            K_SETCOL: cur_col_q <= lim;
            K_SCANMIN: begin
              cmd_q   <= '{start: 1'b1, op: tcs_pkg::UOP_SCAN};
              urow_q  <= phys(cur_row_q, base_q);
              step_q  <= K_MIN;
              state_q <= ST_WAIT;
            end
            K_READ:   cell_q <= urdata;
            default: ;
          endcase
        end
        // result strobe
        ST_OUT: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy                = (state_q != ST_IDLE);
  assign cfg_ready_o         = 1'b1;
  assign done_o              = done_q;
  assign cursor_col_o        = 7'(cur_col_q);
  assign cursor_row_o        = 7'(cur_row_q);
  assign cursor_screen_row_o = 5'(cur_row_q - top_q);
  assign view_top_o          = 7'(top_q);
  assign cell_value_o        = cell_q;

  // the cursor row always lies inside the viewport
  a_cursor_in_view : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_row_q >= top_q) && ({1'b0, cur_row_q - top_q} < SR_W))
    else $error("cursor row outside viewport");

  // the last used row never falls behind the cursor
  a_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q >= cur_row_q)
    else $error("last used row behind cursor");

  // a result is shown only while ready for the next item
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  // the unit is only started when it has nothing in flight
  a_unit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.start |-> !usts.busy && !usts.done)
    else $error("cell unit started while in use");

endmodule
